/* design/first_fit_block_allocator_unit_defines.svh */
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication on clk, disabled in reset
`define FFA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, disabled in reset
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ffa_pkg.sv */
package ffa_pkg;

	localparam int ADDR_W = 32;
	localparam int SIZE_W = 24;
	localparam int CAP_W  = 25;
	localparam int STAT_W = 3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_ALLOCATED = 3'd0,
		STAT_FREED     = 3'd1,
		STAT_NULL      = 3'd2,
		STAT_NO_SPACE  = 3'd3,
		STAT_UNKNOWN   = 3'd4
	} ffa_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ASCAN,
		ST_SHIFT,
		ST_CARVE,
		ST_FSCAN
	} ffa_state_t;

	typedef struct packed {
		logic              start;
		logic [SIZE_W-1:0] size;
	} ffa_rnd_req_t;

	typedef struct packed {
		logic             done;
		logic [CAP_W-1:0] cap;
	} ffa_rnd_rsp_t;

endpackage

/* design/first_fit_block_allocator_unit.sv */
// First-fit heap allocator. Pulse start with operation, request_size and release_address
// while busy is low; the result comes back on data_address, status and reused for exactly
// one cycle with done high and cannot be held off. A zero-size allocate, a null free or a
// free with no carved blocks answers in the cycle after start. A free walks the block table
// one entry per cycle. An allocate first rounds the size, then walks the free list one entry
// per cycle, reading the free-order RAM and, with its registered output, the block-table
// RAM. On a hit that is not the last free entry it then closes the gap in the free list
// (one entry per cycle behind the hit); on a miss it carves a new block at the break
// pointer, or answers no space when the table is full or the block would pass the limit.
// With an empty free list it goes from rounding straight to the carve step. After a hit
// busy stays high while the gap closes, and the next request waits until it is closed.
// No clearing pass is needed after reset.
`include "first_fit_block_allocator_unit_defines.svh"

module first_fit_block_allocator_unit
	import ffa_pkg::*;
#(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 32,
	parameter int ALIGN_BYTES  = 8
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              operation,
	input  logic [SIZE_W-1:0] request_size,
	input  logic [ADDR_W-1:0] release_address,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata,
	output logic              done,
	output logic [ADDR_W-1:0] data_address,
	output logic [STAT_W-1:0] status,
	output logic              reused
);

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int BLK_W = 1 + CAP_W + ADDR_W;
	localparam int END_W = ADDR_W + 2;
	localparam logic [ADDR_W-1:0] HDR     = ADDR_W'(HEADER_BYTES);
	localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_BLOCKS);

	ffa_state_t state_q, state_d;

	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CAP_W-1:0]  cap_q;
	logic [ADDR_W-1:0] limit_q;
	logic [ADDR_W-1:0] break_q;
	logic [CNT_W-1:0]  block_count_q;
	logic [CNT_W-1:0]  free_count_q;
	logic [CNT_W-1:0]  cnt_q;

	logic             v_s1, v_s2;
	logic [CNT_W-1:0] pos_s1, pos_s2;
	logic [IDX_W-1:0] idx_s2;

	logic              done_q;
	logic [ADDR_W-1:0] data_address_q;
	ffa_status_t       status_q;
	logic              reused_q;

	ffa_rnd_req_t rnd_req;
	ffa_rnd_rsp_t rnd_rsp;

	logic             blk_we;
	logic [IDX_W-1:0] blk_waddr, blk_raddr;
	logic [BLK_W-1:0] blk_wdata, blk_rdata;
	logic             fo_we;
	logic [IDX_W-1:0] fo_waddr, fo_raddr;
	logic [IDX_W-1:0] fo_wdata, fo_rdata;

	logic              accept;
	logic              issue;
	logic              a_hit, a_last;
	logic              f_match, f_ok, f_last;
	logic              c_fail;
	logic              clr;
	logic              e_use;
	logic [CAP_W-1:0]  e_cap;
	logic [ADDR_W-1:0] e_base, e_data;
	logic [END_W-1:0]  end_sum;

	logic              fin;
	ffa_status_t       fin_status;
	logic [ADDR_W-1:0] fin_addr;
	logic              fin_reused;

	// block table entry: in-use flag, capacity, base offset
	ffa_ram #(.WIDTH(BLK_W), .DEPTH(MAX_BLOCKS)) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (blk_waddr),
		.wdata (blk_wdata),
		.raddr (blk_raddr),
		.rdata (blk_rdata)
	);

	ffa_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BLOCKS)) u_fo_ram (
		.clk   (clk),
		.we    (fo_we),
		.waddr (fo_waddr),
		.wdata (fo_wdata),
		.raddr (fo_raddr),
		.rdata (fo_rdata)
	);

	ffa_round #(.ALIGN_BYTES(ALIGN_BYTES)) u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rnd_req),
		.rsp    (rnd_rsp)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign e_use   = blk_rdata[BLK_W-1];
	assign e_cap   = blk_rdata[ADDR_W +: CAP_W];
	assign e_base  = blk_rdata[ADDR_W-1:0];
	assign e_data  = e_base + HDR;
	assign end_sum = END_W'(break_q) + END_W'(HEADER_BYTES) + END_W'(cap_q);

	// outputs and datapath control
	always_comb begin
		issue   = 1'b0;
		a_hit   = 1'b0;
		a_last  = 1'b0;
		f_match = 1'b0;
		f_ok    = 1'b0;
		f_last  = 1'b0;
		c_fail  = (block_count_q == MAX_CNT) || (end_sum > END_W'(limit_q));

		blk_we    = 1'b0;
		blk_waddr = idx_s2;
		blk_wdata = {1'b1, e_cap, e_base};
		blk_raddr = cnt_q[IDX_W-1:0];
		fo_we     = 1'b0;
		fo_waddr  = free_count_q[IDX_W-1:0];
		fo_wdata  = pos_s1[IDX_W-1:0];
		fo_raddr  = cnt_q[IDX_W-1:0];

		fin        = 1'b0;
		fin_status = STAT_NULL;
		fin_addr   = '0;
		fin_reused = 1'b0;

		rnd_req.start = 1'b0;
		rnd_req.size  = request_size;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_ALLOC) begin
						if (request_size == '0) begin
							fin = 1'b1;
						end else begin
							rnd_req.start = 1'b1;
						end
					end else if (release_address == '0) begin
						fin = 1'b1;
					end else if (block_count_q == '0) begin
						fin        = 1'b1;
						fin_status = STAT_UNKNOWN;
					end
				end
			end
			ST_ROUND: begin
			end
			ST_ASCAN: begin
				issue     = (cnt_q < free_count_q);
				blk_raddr = fo_rdata;
				if (v_s2) begin
					if (e_cap >= CAP_W'(size_q)) begin
						a_hit      = 1'b1;
						blk_we     = 1'b1;
						fin        = 1'b1;
						fin_status = STAT_ALLOCATED;
						fin_addr   = e_data;
						fin_reused = 1'b1;
					end else if (pos_s2 == free_count_q - 1'b1) begin
						a_last = 1'b1;
					end
				end
			end
			ST_SHIFT: begin
				// close the gap: entry k+1 moves down to k
				issue    = (cnt_q <= free_count_q);
				fo_we    = v_s1;
				fo_waddr = IDX_W'(pos_s1 - 1'b1);
				fo_wdata = fo_rdata;
			end
			ST_CARVE: begin
				fin = 1'b1;
				if (c_fail) begin
					fin_status = STAT_NO_SPACE;
				end else begin
					fin_status = STAT_ALLOCATED;
					fin_addr   = break_q + HDR;
					blk_we     = 1'b1;
					blk_waddr  = block_count_q[IDX_W-1:0];
					blk_wdata  = {1'b1, cap_q, break_q};
				end
			end
			ST_FSCAN: begin
				issue = (cnt_q < block_count_q);
				if (v_s1) begin
					if (e_data == addr_q) begin
						f_match = 1'b1;
						fin     = 1'b1;
						if (e_use && (free_count_q != MAX_CNT)) begin
							f_ok       = 1'b1;
							fin_status = STAT_FREED;
							blk_we     = 1'b1;
							blk_waddr  = pos_s1[IDX_W-1:0];
							blk_wdata  = {1'b0, e_cap, e_base};
							fo_we      = 1'b1;
						end else begin
							fin_status = STAT_UNKNOWN;
						end
					end else if (pos_s1 == block_count_q - 1'b1) begin
						f_last     = 1'b1;
						fin        = 1'b1;
						fin_status = STAT_UNKNOWN;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign clr = a_hit || fin;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_ALLOC) begin
						if (request_size != '0) begin
							state_d = ST_ROUND;
						end
					end else if ((release_address != '0) && (block_count_q != '0)) begin
						state_d = ST_FSCAN;
					end
				end
			end
			ST_ROUND: begin
				if (rnd_rsp.done) begin
					state_d = (free_count_q == '0) ? ST_CARVE : ST_ASCAN;
				end
			end
			ST_ASCAN: begin
				if (a_hit) begin
					state_d = (pos_s2 == free_count_q - 1'b1) ? ST_IDLE : ST_SHIFT;
				end else if (a_last) begin
					state_d = ST_CARVE;
				end
			end
			ST_SHIFT: begin
				if (!issue && !v_s1) begin
					state_d = ST_IDLE;
				end
			end
			ST_CARVE: begin
				state_d = ST_IDLE;
			end
			ST_FSCAN: begin
				if (f_match || f_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			limit_q       <= 32'd65536;
			break_q       <= '0;
			block_count_q <= '0;
			free_count_q  <= '0;
			cnt_q         <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (accept) begin
				cnt_q <= '0;
			end else if (a_hit) begin
				cnt_q <= pos_s2 + 1'b1;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			v_s1 <= clr ? 1'b0 : issue;
			v_s2 <= !clr && v_s1 && (state_q == ST_ASCAN);
			if (a_hit) begin
				free_count_q <= free_count_q - 1'b1;
			end else if (f_ok) begin
				free_count_q <= free_count_q + 1'b1;
			end
			if ((state_q == ST_CARVE) && !c_fail) begin
				break_q       <= end_sum[ADDR_W-1:0];
				block_count_q <= block_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= cnt_q;
		pos_s2 <= pos_s1;
		idx_s2 <= fo_rdata;
		if (accept) begin
			size_q <= request_size;
			addr_q <= release_address;
		end
		if ((state_q == ST_ROUND) && rnd_rsp.done) begin
			cap_q <= rnd_rsp.cap;
		end
		if (fin) begin
			data_address_q <= fin_addr;
			status_q       <= fin_status;
			reused_q       <= fin_reused;
		end
	end

	assign done         = done_q;
	assign data_address = data_address_q;
	assign status       = status_q;
	assign reused       = reused_q;

	`FFA_ASSERT_SAME(a_free_le_blocks, !busy, free_count_q <= block_count_q, "free list longer than block table")
	`FFA_ASSERT_SAME(a_clean_result, done && status != STAT_ALLOCATED, data_address == '0 && !reused, "non-allocation result carries address or reuse")
	`FFA_ASSERT_NEXT(a_carve_answers, state_q == ST_CARVE, done && status != STAT_FREED, "carve step gave no allocation result")

endmodule

/* design/ffa_ram.sv */
module ffa_ram
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/ffa_round.sv */
module ffa_round
	import ffa_pkg::*;
#(
	parameter int ALIGN_BYTES = 8
)
(
	input  logic         clk,
	input  logic         arst_n,
	input  ffa_rnd_req_t req,
	output ffa_rnd_rsp_t rsp
);

	localparam int SH_W  = CAP_W + $clog2(ALIGN_BYTES);
	localparam int RCP_W = CAP_W + 1;
	localparam int PRD_W = CAP_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP =
		RCP_W'(((64'd1 << SH_W) + 64'(ALIGN_BYTES - 1)) / 64'(ALIGN_BYTES));

	logic             run_q;
	logic [CAP_W-1:0] sum_q;
	logic [CAP_W-1:0] quo_q;
	logic [PRD_W-1:0] prod;

	// quotient by reciprocal multiply, exact over the whole sum range
	assign prod = PRD_W'(sum_q) * PRD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= req.start;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sum_q <= CAP_W'(req.size) + CAP_W'(ALIGN_BYTES - 1);
		end
		if (run_q) begin
			quo_q <= CAP_W'(prod >> SH_W);
		end
	end

	assign rsp.done = !run_q;
	assign rsp.cap  = quo_q * CAP_W'(ALIGN_BYTES);

endmodule
